// ----- sv/hfe_pkg.sv -----
// Shared constants and types for the Huffman encoder bit packer.
package hfe_pkg;

    // Alphabet and table geometry
    localparam int NUM_SYMBOLS  = 257;
    localparam int SYM_W        = 9;
    localparam int ADDR_W       = $clog2(NUM_SYMBOLS);
    localparam int CW_W         = 32;
    localparam int LEN_W        = 6;
    localparam int MAX_CODE_LEN = 32;
    localparam int LEN_CAP      = (MAX_CODE_LEN < CW_W) ? MAX_CODE_LEN : CW_W;

    // Byte packer
    localparam int BYTE_W = 8;
    localparam int FREE_W = 4;

    // Queue between lookup and packer
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Command codes
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    // End-of-stream table index
    localparam logic [SYM_W-1:0] END_SYMBOL = SYM_W'(NUM_SYMBOLS - 1);

    // One code table entry
    typedef struct packed {
        logic [CW_W-1:0]  code;
        logic [LEN_W-1:0] len;
    } table_entry_t;

    // One packing job handed from lookup to packer
    typedef struct packed {
        logic [CW_W-1:0]  code;
        logic [LEN_W-1:0] len;
        logic             fin;
    } pack_job_t;

endpackage

// ----- sv/huffman_encoder_bit_packer.sv -----
// Top level of the Huffman encoder bit packer.
//
//  Channel   Dir  Handshake          Payload
//  s_*       in   s_tvalid/s_tready  s_tdata: command, symbol, codeword_bits, codeword_length
//  m_*       out  m_tvalid/m_tready  m_tdata: out_byte; m_tlast: last byte of a request
//
//  A load request writes the code table. An encode or finish request reads the
//  code table (registered read port) and is then pushed into a four-entry queue
//  once the queue has room. The packer takes a job, completes its bytes one by
//  one, and takes a last step when bits are left for the partial byte or the
//  code is empty; a finish emits its flush byte in that last step. The packer
//  emits at most one byte per cycle. Reset clears the packer and queue; the
//  table is unset. A stalled output holds the packer; the front keeps taking
//  requests until the queue and the lookup stage are full.
module huffman_encoder_bit_packer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // command[1:0], symbol[10:2], codeword_bits[42:11],
                                   // codeword_length[48:43], zero[55:49]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast
);

    hfe_pkg::pack_job_t front_job;
    hfe_pkg::pack_job_t head_job;
    logic               job_push;
    logic               q_full;
    logic               q_not_empty;
    logic               q_pop;

    // Lookup front end
    hfe_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (s_tvalid),
        .req_ready       (s_tready),
        .command         (s_tdata[1:0]),
        .symbol          (s_tdata[10:2]),
        .codeword_bits   (s_tdata[42:11]),
        .codeword_length (s_tdata[48:43]),
        .job_valid       (job_push),
        .job_full        (q_full),
        .job             (front_job)
    );

    // Job queue
    hfe_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_job  (front_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head_job)
    );

    // Bit packer
    hfe_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (q_not_empty),
        .job       (head_job),
        .job_pop   (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// ----- sv/hfe_front.sv -----
// Front end: accepts requests, loads the code table, looks up codes to pack.
module hfe_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  logic [1:0]                command,
    input  logic [hfe_pkg::SYM_W-1:0] symbol,
    input  logic [hfe_pkg::CW_W-1:0]  codeword_bits,
    input  logic [hfe_pkg::LEN_W-1:0] codeword_length,
    output logic                      job_valid,
    input  logic                      job_full,
    output hfe_pkg::pack_job_t        job
);

    hfe_pkg::table_entry_t code_mem [hfe_pkg::NUM_SYMBOLS];

    hfe_pkg::table_entry_t rd_data_reg;
    logic                  st_valid_reg, st_valid_next;
    logic                  st_fin_reg;

    logic                          accept;
    logic                          sym_ok;
    logic                          do_load;
    logic                          do_lookup;
    logic                          push;
    logic [hfe_pkg::SYM_W-1:0]     rd_sym;
    logic [hfe_pkg::LEN_W-1:0]     len_sat;
    hfe_pkg::table_entry_t         wr_data;

    // Request decode
    assign push      = st_valid_reg && !job_full;
    assign req_ready = !st_valid_reg || !job_full;
    assign accept    = req_valid && req_ready;
    assign sym_ok    = (symbol < hfe_pkg::SYM_W'(hfe_pkg::NUM_SYMBOLS));
    assign do_load   = accept && (command == hfe_pkg::CMD_LOAD) && sym_ok;
    assign do_lookup = accept && (((command == hfe_pkg::CMD_ENCODE) && sym_ok)
                                  || (command == hfe_pkg::CMD_FINISH));
    assign rd_sym    = (command == hfe_pkg::CMD_FINISH) ? hfe_pkg::END_SYMBOL : symbol;

    // Length saturates at the codeword width
    assign len_sat = (codeword_length > hfe_pkg::LEN_W'(hfe_pkg::LEN_CAP))
                     ? hfe_pkg::LEN_W'(hfe_pkg::LEN_CAP) : codeword_length;
    assign wr_data = '{code: codeword_bits, len: len_sat};

    // Code table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            code_mem[symbol[hfe_pkg::ADDR_W-1:0]] <= wr_data;
        end
        if (do_lookup)
        begin
            rd_data_reg <= code_mem[rd_sym[hfe_pkg::ADDR_W-1:0]];
            st_fin_reg  <= (command == hfe_pkg::CMD_FINISH);
        end
    end

    // Lookup stage occupancy
    always_comb
    begin
        st_valid_next = st_valid_reg;
        if (push)
        begin
            st_valid_next = 1'b0;
        end
        if (do_lookup)
        begin
            st_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
        end
        else
        begin
            st_valid_reg <= st_valid_next;
        end
    end

    assign job_valid = push;
    assign job       = '{code: rd_data_reg.code, len: rd_data_reg.len, fin: st_fin_reg};

endmodule

// ----- sv/hfe_queue.sv -----
// Small FIFO of packing jobs between the lookup front end and the packer.
module hfe_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hfe_pkg::pack_job_t push_job,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output hfe_pkg::pack_job_t head
);

    hfe_pkg::pack_job_t slots [hfe_pkg::QUEUE_DEPTH];

    logic [hfe_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [hfe_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [hfe_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                       do_pop;

    assign full      = (count_reg == hfe_pkg::QCNT_W'(hfe_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_pop    = pop && not_empty;
    assign head      = slots[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count
    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- sv/hfe_back.sv -----
// Back end: shifts codes MSB-first into the byte accumulator and emits bytes.
module hfe_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       job_avail,
    input  hfe_pkg::pack_job_t         job,
    output logic                       job_pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [hfe_pkg::BYTE_W-1:0] out_byte,
    output logic                       out_last
);

    // Current job
    logic                          busy_reg, busy_next;
    logic [hfe_pkg::CW_W-1:0]      shift_reg, shift_next;
    logic [hfe_pkg::LEN_W-1:0]     rem_reg, rem_next;
    logic                          fin_reg, fin_next;

    // Packer state
    logic [hfe_pkg::BYTE_W-1:0]    acc_reg, acc_next;
    logic [hfe_pkg::FREE_W-1:0]    free_reg, free_next;

    // Output register
    logic                          ovalid_reg, ovalid_next;
    logic [hfe_pkg::BYTE_W-1:0]    obyte_reg, obyte_next;
    logic                          olast_reg, olast_next;

    logic                          can_step;
    logic [hfe_pkg::LEN_W-1:0]     free_ext;
    logic [hfe_pkg::BYTE_W-1:0]    top_bits;
    logic [2*hfe_pkg::BYTE_W-1:0]  pair_fill;
    logic [2*hfe_pkg::BYTE_W-1:0]  pair_part;
    logic [hfe_pkg::BYTE_W-1:0]    acc_part;
    logic [hfe_pkg::FREE_W-1:0]    free_part;
    logic [hfe_pkg::LEN_W-1:0]     left_after;

    assign can_step   = !ovalid_reg || out_ready;
    assign free_ext   = hfe_pkg::LEN_W'(free_reg);
    assign top_bits   = shift_reg[hfe_pkg::CW_W-1 -: hfe_pkg::BYTE_W];
    assign pair_fill  = {acc_reg, top_bits} << free_reg;
    assign pair_part  = {acc_reg, top_bits} << rem_reg;
    assign acc_part   = pair_part[2*hfe_pkg::BYTE_W-1 -: hfe_pkg::BYTE_W];
    assign free_part  = free_reg - rem_reg[hfe_pkg::FREE_W-1:0];
    assign left_after = rem_reg - free_ext;
    assign job_pop    = !busy_reg && job_avail;

    always_comb
    begin
        busy_next   = busy_reg;
        shift_next  = shift_reg;
        rem_next    = rem_reg;
        fin_next    = fin_reg;
        acc_next    = acc_reg;
        free_next   = free_reg;
        ovalid_next = ovalid_reg && !out_ready;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;

        if (!busy_reg)
        begin
            // Take a job and left-align its code
            if (job_avail)
            begin
                busy_next  = 1'b1;
                shift_next = job.code << (hfe_pkg::LEN_W'(hfe_pkg::CW_W) - job.len);
                rem_next   = job.len;
                fin_next   = job.fin;
            end
        end
        else if (can_step)
        begin
            if (rem_reg >= free_ext)
            begin
                // Enough bits to complete the current byte
                ovalid_next = 1'b1;
                obyte_next  = pair_fill[2*hfe_pkg::BYTE_W-1 -: hfe_pkg::BYTE_W];
                olast_next  = fin_reg ? (left_after == '0)
                                      : (left_after < hfe_pkg::LEN_W'(hfe_pkg::BYTE_W));
                shift_next  = shift_reg << free_reg;
                rem_next    = left_after;
                acc_next    = '0;
                free_next   = hfe_pkg::FREE_W'(hfe_pkg::BYTE_W);
                busy_next   = (left_after != '0);
            end
            else
            begin
                // Remaining bits fit in the partial byte
                busy_next = 1'b0;
                rem_next  = '0;
                if (fin_reg && (free_part != hfe_pkg::FREE_W'(hfe_pkg::BYTE_W)))
                begin
                    // Flush the partial byte left-aligned
                    ovalid_next = 1'b1;
                    obyte_next  = acc_part << free_part;
                    olast_next  = 1'b1;
                    acc_next    = '0;
                    free_next   = hfe_pkg::FREE_W'(hfe_pkg::BYTE_W);
                end
                else if (fin_reg)
                begin
                    acc_next  = '0;
                    free_next = hfe_pkg::FREE_W'(hfe_pkg::BYTE_W);
                end
                else
                begin
                    acc_next  = acc_part;
                    free_next = free_part;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        fin_reg   <= fin_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

    // Control and packer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            acc_reg    <= '0;
            free_reg   <= hfe_pkg::FREE_W'(hfe_pkg::BYTE_W);
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            acc_reg    <= acc_next;
            free_reg   <= free_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_byte  = obyte_reg;
    assign out_last  = olast_reg;

endmodule
